/* sv/mnps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mnps_pkg;

    // default number of held-note entries
    localparam int DEF_STACK_DEPTH = 16;

    localparam int NOTE_W  = 7;
    localparam int COUNT_W = 5;

    // transaction modes
    typedef enum logic [1:0] {
        MODE_NOTE_ON  = 2'd0,
        MODE_NOTE_OFF = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [NOTE_W-1:0] note;
        logic              accent;
    } in_t;

    typedef struct packed {
        logic [NOTE_W-1:0]  front_note;
        logic               front_accent;
        logic [COUNT_W-1:0] held_count;
        logic               any_held;
        logic               release_found;
    } out_t;

    // one stack entry
    typedef struct packed {
        logic              accent;
        logic [NOTE_W-1:0] note;
    } entry_t;

endpackage

`default_nettype wire

/* sv/mono_note_priority_stack_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// s_        in   s_valid / s_ready    s_data  (mode, note, accent)
// m_        out  m_valid / m_ready    m_data  (front_note, front_accent, held_count,
//                                              any_held, release_found)
//
// one transaction at a time; s_ready is high only in the idle state
// note-on: read/write move pass toward the back, front write, then front read
// note-off: search from the oldest, move the entries behind the match toward the front, then front read
// clear: no memory access; unused mode: front read only
// aresetn (synchronous, active low) clears the count and control; memory is not cleared
// a stalled result holds in the output register; the next transaction then waits to finish

module mono_note_priority_stack_unit
    import mnps_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire in_t  s_data,
    input  wire logic s_valid,
    output logic      s_ready,
    output out_t      m_data,
    output logic      m_valid,
    input  wire logic m_ready
);

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int CW1 = CW + 1;

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SRCH_RD  = 8'b0000_0010,  // read entry under search pointer
        ST_SRCH_CMP = 8'b0000_0100,  // compare pitch
        ST_MV_RD    = 8'b0000_1000,  // read source entry of a move
        ST_MV_WR    = 8'b0001_0000,  // write it one place over
        ST_PUSH_WR  = 8'b0010_0000,  // write new note at the front
        ST_FRONT_RD = 8'b0100_0000,  // read the front entry
        ST_DONE     = 8'b1000_0000   // load the result register
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic            mv_up_reg, mv_up_next;     // 1: move toward front (note-off)
    logic            found_reg, found_next;
    in_t             item_reg;
    out_t            m_data_reg;
    logic            m_valid_reg, m_valid_next;

    // entry memory, one read and one write port
    entry_t          mem [STACK_DEPTH];
    entry_t          rd_data_reg;
    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;
    entry_t          wr_data;

    logic            full;
    logic [CW1-1:0]  ptr_p1, ptr_p2;
    logic [AW-1:0]   push_last;
    logic [CW+4:0]   count_wide;

    assign full      = (count_reg == CW'(STACK_DEPTH));
    assign ptr_p1    = CW1'(ptr_reg) + CW1'(1);
    assign ptr_p2    = CW1'(ptr_reg) + CW1'(2);
    assign push_last = full ? AW'(STACK_DEPTH - 1) : AW'(count_reg);
    assign count_wide = {5'd0, count_reg};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        mv_up_next   = mv_up_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = ptr_reg;
        wr_data      = rd_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    found_next = 1'b0;
                    case (mode_t'(s_data.mode))
                        MODE_NOTE_ON: begin
                            if (count_reg == '0) begin
                                state_next = ST_PUSH_WR;
                            end else begin
                                ptr_next   = push_last;
                                mv_up_next = 1'b0;
                                state_next = ST_MV_RD;
                            end
                        end
                        MODE_NOTE_OFF: begin
                            if (count_reg == '0) begin
                                state_next = ST_FRONT_RD;
                            end else begin
                                ptr_next   = AW'(count_reg - CW'(1));
                                state_next = ST_SRCH_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_FRONT_RD;
                        end
                    endcase
                end
            end
            ST_SRCH_RD: begin
                rd_en      = 1'b1;
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (rd_data_reg.note == item_reg.note) begin
                    found_next = 1'b1;
                    if (ptr_p1 < {1'b0, count_reg}) begin
                        mv_up_next = 1'b1;
                        state_next = ST_MV_RD;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_FRONT_RD;
                    end
                end else if (ptr_reg == '0) begin
                    state_next = ST_FRONT_RD;
                end else begin
                    ptr_next   = ptr_reg - AW'(1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_MV_RD: begin
                rd_en      = 1'b1;
                rd_addr    = mv_up_reg ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
                state_next = ST_MV_WR;
            end
            ST_MV_WR: begin
                wr_en = 1'b1;
                if (mv_up_reg) begin
                    // close the gap left by the released note
                    if (ptr_p2 < {1'b0, count_reg}) begin
                        ptr_next   = ptr_reg + AW'(1);
                        state_next = ST_MV_RD;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_FRONT_RD;
                    end
                end else begin
                    // open a slot at the front, oldest falls off when full
                    if (ptr_reg == AW'(1)) begin
                        state_next = ST_PUSH_WR;
                    end else begin
                        ptr_next   = ptr_reg - AW'(1);
                        state_next = ST_MV_RD;
                    end
                end
            end
            ST_PUSH_WR: begin
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_data.note   = item_reg.note;
                wr_data.accent = item_reg.accent;
                if (!full) begin
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_FRONT_RD;
            end
            ST_FRONT_RD: begin
                rd_en      = (count_reg != '0);
                rd_addr    = '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            mv_up_reg   <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            mv_up_reg   <= mv_up_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // captured transaction and result payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_data_reg.any_held      <= (count_reg != '0);
            m_data_reg.front_note    <= (count_reg != '0) ? rd_data_reg.note : '0;
            m_data_reg.front_accent  <= (count_reg != '0) ? rd_data_reg.accent : 1'b0;
            m_data_reg.held_count    <= count_wide[4:0];
            m_data_reg.release_found <= found_reg;
        end
    end

    // count never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("held count above stack depth");

    // search pointer stays among held entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRCH_RD || state_reg == ST_SRCH_CMP) |-> (CW'(ptr_reg) < count_reg))
        else $error("search pointer outside held entries");

    // a clear leaves nothing held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && item_reg.mode == MODE_CLEAR) |-> (count_reg == '0))
        else $error("clear left entries held");

    // an empty result carries a zero front note
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.any_held) |->
            (m_data_reg.front_note == '0 && !m_data_reg.front_accent))
        else $error("front note set with nothing held");

    // found only on a note-off result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && found_reg) |-> (item_reg.mode == MODE_NOTE_OFF))
        else $error("release found on a non note-off transaction");

endmodule

`default_nettype wire

/* tb/held_note_checker.sv */
`timescale 1ns / 1ps

// watches both channels, tracks the held-note stack and checks every result
module held_note_checker
    import mnps_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire in_t  s_data,
    input  wire logic s_valid,
    input  wire logic s_ready,
    input  wire out_t m_data,
    input  wire logic m_valid,
    input  wire logic m_ready,
    output int        err_count,
    output int        voices_due
);

    logic [NOTE_W-1:0] pitch_mem  [STACK_DEPTH];
    logic              accent_mem [STACK_DEPTH];
    int                depth_now;
    out_t              voice_due_q [$];
    int                errs;

    initial begin
        depth_now  = 0;
        errs       = 0;
        err_count  = 0;
        voices_due = 0;
    end

    // newest entry at index 0, oldest falls off the end when full
    task automatic push_note(input logic [NOTE_W-1:0] nt, input logic ac);
        int last;
        last = (depth_now < STACK_DEPTH) ? depth_now : STACK_DEPTH - 1;
        for (int k = last; k > 0; k--) begin
            pitch_mem[k]  = pitch_mem[k-1];
            accent_mem[k] = accent_mem[k-1];
        end
        pitch_mem[0]  = nt;
        accent_mem[0] = ac;
        if (depth_now < STACK_DEPTH)
            depth_now++;
    endtask

    // search from the oldest entry, remove the first equal pitch
    task automatic drop_note(input logic [NOTE_W-1:0] nt, output logic found);
        int k;
        found = 1'b0;
        k = depth_now;
        while (k > 0 && !found) begin
            k--;
            if (pitch_mem[k] == nt) begin
                for (int j = k; j + 1 < depth_now; j++) begin
                    pitch_mem[j]  = pitch_mem[j+1];
                    accent_mem[j] = accent_mem[j+1];
                end
                depth_now--;
                found = 1'b1;
            end
        end
    endtask

    task automatic apply_note_event(input in_t ev, output out_t voice);
        logic found;
        found = 1'b0;
        case (mode_t'(ev.mode))
            MODE_NOTE_ON:  push_note(ev.note, ev.accent);
            MODE_NOTE_OFF: drop_note(ev.note, found);
            MODE_CLEAR:    depth_now = 0;
            default: ;
        endcase
        voice = '0;
        if (depth_now > 0) begin
            voice.front_note   = pitch_mem[0];
            voice.front_accent = accent_mem[0];
            voice.any_held     = 1'b1;
        end
        voice.held_count    = COUNT_W'(depth_now);
        voice.release_found = found;
    endtask

    always @(posedge aclk) begin : watch
        out_t want;
        logic bad;
        if (!aresetn) begin
            voice_due_q.delete();
            depth_now = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (voice_due_q.size() == 0) begin
                    if (errs < 10)
                        $display("%0t: result transaction with nothing expected", $time);
                    errs++;
                end else begin
                    want = voice_due_q.pop_front();
                    bad = (m_data.front_note    !== want.front_note)
                       || (m_data.front_accent  !== want.front_accent)
                       || (m_data.held_count    !== want.held_count)
                       || (m_data.any_held      !== want.any_held)
                       || (m_data.release_found !== want.release_found);
                    if (bad) begin
                        if (errs < 10)
                            $display("%0t: mismatch exp note %0d acc %0b cnt %0d any %0b fnd %0b",
                                     $time, want.front_note, want.front_accent,
                                     want.held_count, want.any_held, want.release_found,
                                     " | got note %0d acc %0b cnt %0d any %0b fnd %0b",
                                     m_data.front_note, m_data.front_accent,
                                     m_data.held_count, m_data.any_held,
                                     m_data.release_found);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_note_event(s_data, want);
                voice_due_q.push_back(want);
            end
        end
        err_count  <= errs;
        voices_due <= voice_due_q.size();
    end

endmodule

/* tb/tb_mono_note_priority_stack_unit.sv */
`timescale 1ns / 1ps

module tb_mono_note_priority_stack_unit;
    import mnps_pkg::*;

    localparam int DEPTH            = DEF_STACK_DEPTH;
    localparam int ITEMS_PER_PHASE  = 600;   // three phases, about 1800 random transactions
    localparam int LONG_HOLD_CYCLES = 400;   // long enough to back up the input side
    localparam int SETTLE_CYCLES    = 100;   // longer than the worst note-off path

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    in_t  s_data  = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    out_t m_data;
    logic m_valid;
    logic m_ready = 1'b0;

    // idle odds in percent per cycle, changed per phase
    int send_idle_pct = 37;
    int recv_idle_pct = 76;

    // long receiver hold requests, raised by stimulus and served by the receiver
    int hold_reqs = 0;

    int err_count;
    int voices_due;

    mono_note_priority_stack_unit #(
        .STACK_DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    held_note_checker #(
        .STACK_DEPTH(DEPTH)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_data     (m_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .err_count  (err_count),
        .voices_due (voices_due)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop if the run hangs
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random back-pressure, plus a long hold when asked
    initial begin : result_side
        int hold_left;
        int holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != holds_taken) begin
                holds_taken = hold_reqs;
                hold_left   = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic in_t make_event(input mode_t m, input int nt, input logic ac);
        in_t ev;
        ev.mode   = m;
        ev.note   = NOTE_W'(nt);
        ev.accent = ac;
        return ev;
    endfunction

    // mostly pitches from a narrow pool so note-offs hit held notes and duplicates occur
    function automatic in_t rand_event(input int on_pct);
        in_t ev;
        int  r;
        r = $urandom_range(99);
        if (r < 3)
            ev.mode = MODE_CLEAR;
        else if (r < 5)
            ev.mode = MODE_UNUSED;
        else if (r < 5 + on_pct)
            ev.mode = MODE_NOTE_ON;
        else
            ev.mode = MODE_NOTE_OFF;
        if ($urandom_range(4) == 0)
            ev.note = NOTE_W'($urandom_range(127));
        else
            ev.note = NOTE_W'(48 + $urandom_range(23));
        ev.accent = 1'($urandom_range(1));
        return ev;
    endfunction

    // offer one transaction; valid stays up after acceptance unless the next gap lowers it
    task automatic offer_event(input in_t ev);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= ev;
        s_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (voices_due != 0);
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input logic pressure);
        int on_pct;
        on_pct        = 50;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // swing between filling and emptying the stack
            if (i % 50 == 0)
                on_pct = ($urandom_range(1) == 1) ? 60 : 30;
            // receiver holds off while the sender keeps offering
            if (pressure && i == ITEMS_PER_PHASE / 2)
                hold_reqs <= hold_reqs + 1;
            // sender pauses until everything has come out
            if (pressure && i == 3 * ITEMS_PER_PHASE / 4)
                wait_for_drain();
            offer_event(rand_event(on_pct));
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty stack cases
        offer_event(make_event(MODE_NOTE_OFF, 64, 1'b0));
        offer_event(make_event(MODE_CLEAR, 0, 1'b1));
        // pitch extremes and a duplicate pitch; note-off takes the older copy
        offer_event(make_event(MODE_NOTE_ON, 0, 1'b0));
        offer_event(make_event(MODE_NOTE_ON, 127, 1'b1));
        offer_event(make_event(MODE_NOTE_ON, 127, 1'b0));
        offer_event(make_event(MODE_NOTE_OFF, 127, 1'b1));
        // unused mode with notes held, then clear
        offer_event(make_event(MODE_UNUSED, 127, 1'b1));
        offer_event(make_event(MODE_CLEAR, 0, 1'b0));
        // overfill by one so the oldest note is dropped
        for (int k = 0; k <= DEPTH; k++)
            offer_event(make_event(MODE_NOTE_ON, k * 7 + 3, k[0]));
        // the dropped pitch is gone, the next oldest is still there
        offer_event(make_event(MODE_NOTE_OFF, 3, 1'b0));
        offer_event(make_event(MODE_NOTE_OFF, 10, 1'b0));
        wait_for_drain();

        // random traffic in three idling phases
        run_phase(37, 76, 1'b1);
        wait_for_drain();
        run_phase(76, 37, 1'b1);
        wait_for_drain();
        run_phase(0, 0, 1'b0);
        wait_for_drain();

        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0 && voices_due == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
